/* src/mck_pkg.sv */
`timescale 1ns / 1ps
// mck_pkg: shared types, constants and the Morse code table for the character keyer.
// No dependencies.
package mck_pkg;

  localparam int MAX_ELEMENTS = 5;
  localparam int CODE_W       = 5;
  localparam int ELEM_W       = $clog2(MAX_ELEMENTS + 1);
  localparam int ELEM_IDX_W   = $clog2(MAX_ELEMENTS);

  localparam int BASE_W  = 16;
  localparam int FACT_W  = 4;
  localparam int DUR_W   = BASE_W + FACT_W;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 2;
  localparam int TDATA_W = ((DUR_W + 1 + 7) / 8) * 8;

  localparam logic [INDEX_W-1:0] REG_BASE_DURATION = 2'd0;
  localparam logic [INDEX_W-1:0] REG_DASH_UNITS    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_WORD_UNITS    = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET  = 16'd500;
  localparam logic [FACT_W-1:0] SHORT_RESET = 4'd3;
  localparam logic [FACT_W-1:0] LONG_RESET  = 4'd7;

  typedef enum logic [1:0] {
    CH_DROP   = 2'd0,
    CH_SPACE  = 2'd1,
    CH_SYMBOL = 2'd2
  } char_kind_t;

  typedef struct packed {
    char_kind_t              kind;
    logic [ELEM_W-1:0]       len;
    logic [MAX_ELEMENTS-1:0] pat;   // bit i set: element i is a dash
  } morse_code_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_EMIT  = 3'b100
  } seq_state_t;

  function automatic morse_code_t morse_lookup(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] fold;
    logic [CODE_W-1:0] code;
    logic [2:0]        n;
    morse_code_t       r;
    fold = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    code = '0;
    n    = '0;
    r.kind = CH_SYMBOL;
    case (fold)
      "A": begin code = 5'b00010; n = 3'd2; end
      "B": begin code = 5'b00001; n = 3'd4; end
      "C": begin code = 5'b00101; n = 3'd4; end
      "D": begin code = 5'b00001; n = 3'd3; end
      "E": begin code = 5'b00000; n = 3'd1; end
      "F": begin code = 5'b00100; n = 3'd4; end
      "G": begin code = 5'b00011; n = 3'd3; end
      "H": begin code = 5'b00000; n = 3'd4; end
      "I": begin code = 5'b00000; n = 3'd2; end
      "J": begin code = 5'b01110; n = 3'd4; end
      "K": begin code = 5'b00101; n = 3'd3; end
      "L": begin code = 5'b00010; n = 3'd4; end
      "M": begin code = 5'b00011; n = 3'd2; end
      "N": begin code = 5'b00001; n = 3'd2; end
      "O": begin code = 5'b00111; n = 3'd3; end
      "P": begin code = 5'b00110; n = 3'd4; end
      "Q": begin code = 5'b01011; n = 3'd4; end
      "R": begin code = 5'b00010; n = 3'd3; end
      "S": begin code = 5'b00000; n = 3'd3; end
      "T": begin code = 5'b00001; n = 3'd1; end
      "U": begin code = 5'b00100; n = 3'd3; end
      "V": begin code = 5'b01000; n = 3'd4; end
      "W": begin code = 5'b00110; n = 3'd3; end
      "X": begin code = 5'b01001; n = 3'd4; end
      "Y": begin code = 5'b01101; n = 3'd4; end
      "Z": begin code = 5'b00011; n = 3'd4; end
      "0": begin code = 5'b11111; n = 3'd5; end
      "1": begin code = 5'b11110; n = 3'd5; end
      "2": begin code = 5'b11100; n = 3'd5; end
      "3": begin code = 5'b11000; n = 3'd5; end
      "4": begin code = 5'b10000; n = 3'd5; end
      "5": begin code = 5'b00000; n = 3'd5; end
      "6": begin code = 5'b00001; n = 3'd5; end
      "7": begin code = 5'b00011; n = 3'd5; end
      "8": begin code = 5'b00111; n = 3'd5; end
      "9": begin code = 5'b01111; n = 3'd5; end
      " ": r.kind = CH_SPACE;
      default: r.kind = CH_DROP;
    endcase
    r.pat = MAX_ELEMENTS'(code);
    r.len = (int'(n) > MAX_ELEMENTS) ? ELEM_W'(MAX_ELEMENTS) : ELEM_W'(n);
    return r;
  endfunction

endpackage

/* src/mck_dur_mul.sv */
`timescale 1ns / 1ps
// mck_dur_mul: shared registered multiplier, unit count times base duration.
// Depends on mck_pkg.
module mck_dur_mul
  import mck_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [FACT_W-1:0] units,
  input  logic [BASE_W-1:0] base,
  output logic [DUR_W-1:0]  product
);

  always_ff @(posedge clk) begin
    if (en) begin
      product <= {{BASE_W{1'b0}}, units} * {{FACT_W{1'b0}}, base};
    end
  end

endmodule

/* src/morse_character_keyer_core.sv */
`timescale 1ns / 1ps
// morse_character_keyer_core: top level, turns one character into timed light segments.
// Depends on mck_pkg and mck_dur_mul.
//
//  channel  | direction | tdata / payload                  | side band
//  s_*      | in        | [7:0] character                  | -
//  m_*      | out       | [0] light_on, [20:1] duration    | tlast = last_of_char
//  cfg_*    | in        | cfg_index, cfg_data              | -
//
// Each segment passes through the shared multiplier in an issue step and an emit step;
// a letter or digit of n elements gives 2n+1 segments, a space one, others none.
// Output stalls hold the sequencer in its emit step; s_tready is low meanwhile.
// Reset (rst, synchronous) restores the default registers and empties the output.
module morse_character_keyer_core
  import mck_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [0] light_on, [20:1] duration, rest zero
  output logic               m_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]  cfg_data
);

  logic [BASE_W-1:0] base_duration;
  logic [FACT_W-1:0] dash_units;
  logic [FACT_W-1:0] word_units;

  seq_state_t              state, state_next;
  morse_code_t             cur;
  logic [ELEM_W-1:0]       elem;
  logic                    phase;   // 0: lit element next, 1: its trailing dark unit
  logic                    pend_lit;
  logic                    pend_last;
  logic [FACT_W-1:0]       units;
  logic                    seg_lit;
  logic                    seg_last;
  logic                    out_free;
  logic [DUR_W-1:0]        product;
  morse_code_t             lookup;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign lookup    = morse_lookup(s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_duration <= BASE_RESET;
      dash_units    <= SHORT_RESET;
      word_units    <= LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_DURATION: base_duration <= cfg_data;
        REG_DASH_UNITS:    dash_units    <= cfg_data[FACT_W-1:0];
        REG_WORD_UNITS:    word_units    <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // segment selection
  always_comb begin
    seg_last = 1'b0;
    seg_lit  = 1'b0;
    units    = FACT_W'(1);
    if (cur.kind == CH_SPACE) begin
      seg_last = 1'b1;
      units    = word_units;
    end else if (elem == cur.len) begin
      seg_last = 1'b1;
      units    = dash_units;
    end else if (!phase) begin
      seg_lit = 1'b1;
      units   = cur.pat[elem[ELEM_IDX_W-1:0]] ? dash_units : FACT_W'(1);
    end
  end

  mck_dur_mul u_mul (
    .clk     (clk),
    .en      (state == ST_ISSUE),
    .units   (units),
    .base    (base_duration),
    .product (product)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && lookup.kind != CH_DROP) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = pend_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cur   <= lookup;
      elem  <= '0;
      phase <= 1'b0;
    end
    if (state == ST_ISSUE) begin
      pend_lit  <= seg_lit;
      pend_last <= seg_last;
      if (phase) begin
        elem <= elem + ELEM_W'(1);
      end
      phase <= seg_lit;
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= TDATA_W'({product, pend_lit});
      m_tlast <= pend_last;
    end
  end

endmodule

/* src/mck_checker.sv */
`timescale 1ns / 1ps
// mck_checker: port-level assertions for the keyer, bound to the top level.
// Depends on mck_pkg and morse_character_keyer_core.
module mck_checker
  import mck_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // a lit segment never closes a character
  a_lit_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tlast)
    else $error("lit segment marked last");

  // after a lit transfer the character is still in progress
  a_lit_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[0] |=> !s_tready)
    else $error("input ready before character finished");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TDATA_W-1:DUR_W+1] == '0)
    else $error("tdata padding not zero");

endmodule

bind morse_character_keyer_core mck_checker u_mck_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* dv/mck_segment_checker.sv */
`timescale 1ns / 1ps
// mck_segment_checker: watches the character, segment and register channels of the keyer,
// works out each segment it should send and compares it with what it sends.
// Depends on mck_pkg.
module mck_segment_checker
  import mck_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,   // [0] light_on, [20:1] duration, rest zero
  input  logic               m_tlast,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 segments_checked
);

  typedef struct packed {
    logic             lit;
    logic [DUR_W-1:0] ticks;
    logic             last;
  } segment_t;

  segment_t          expected_segments[$];
  logic [BASE_W-1:0] unit_ticks;
  logic [FACT_W-1:0] dash_units;
  logic [FACT_W-1:0] word_units;

  function automatic string morse_pattern(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    string             p;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (up)
      "A": p = ".-";    "B": p = "-...";  "C": p = "-.-.";  "D": p = "-..";
      "E": p = ".";     "F": p = "..-.";  "G": p = "--.";   "H": p = "....";
      "I": p = "..";    "J": p = ".---";  "K": p = "-.-";   "L": p = ".-..";
      "M": p = "--";    "N": p = "-.";    "O": p = "---";   "P": p = ".--.";
      "Q": p = "--.-";  "R": p = ".-.";   "S": p = "...";   "T": p = "-";
      "U": p = "..-";   "V": p = "...-";  "W": p = ".--";   "X": p = "-..-";
      "Y": p = "-.--";  "Z": p = "--..";
      "0": p = "-----"; "1": p = ".----"; "2": p = "..---"; "3": p = "...--";
      "4": p = "....-"; "5": p = "....."; "6": p = "-...."; "7": p = "--...";
      "8": p = "---.."; "9": p = "----.";
      default: p = "";
    endcase
    return p;
  endfunction

  function automatic segment_t make_segment(input logic lit, input logic [FACT_W-1:0] units,
                                            input logic last);
    segment_t s;
    s.lit   = lit;
    s.ticks = DUR_W'(units) * DUR_W'(unit_ticks);
    s.last  = last;
    return s;
  endfunction

  task automatic predict_segments(input logic [CHAR_W-1:0] ch);
    string             pat;
    logic [FACT_W-1:0] units;
    pat = morse_pattern(ch);
    if (ch == " ") begin
      expected_segments.push_back(make_segment(1'b0, word_units, 1'b1));
    end else if (pat.len() > 0) begin
      for (int i = 0; i < pat.len() && i < MAX_ELEMENTS; i++) begin
        units = (pat[i] == "-") ? dash_units : FACT_W'(1);
        expected_segments.push_back(make_segment(1'b1, units, 1'b0));
        expected_segments.push_back(make_segment(1'b0, FACT_W'(1), 1'b0));
      end
      expected_segments.push_back(make_segment(1'b0, dash_units, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (rst) begin
      unit_ticks = BASE_RESET;
      dash_units = SHORT_RESET;
      word_units = LONG_RESET;
      expected_segments.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.lit   = m_tdata[0];
        got.ticks = m_tdata[DUR_W:1];
        got.last  = m_tlast;
        segments_checked++;
        if (expected_segments.size() == 0) begin
          fail_count++;
          $display("%0t: segment with none expected: light_on=%0b duration=%0d last=%0b",
                   $time, got.lit, got.ticks, got.last);
        end else begin
          want = expected_segments.pop_front();
          if (got !== want || m_tdata[TDATA_W-1:DUR_W+1] !== '0) begin
            fail_count++;
            $display("%0t: segment mismatch: expected light_on=%0b duration=%0d last=%0b pad=0",
                     $time, want.lit, want.ticks, want.last);
            $display("%0t:                   actual light_on=%0b duration=%0d last=%0b pad=%h",
                     $time, got.lit, got.ticks, got.last, m_tdata[TDATA_W-1:DUR_W+1]);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_DURATION: unit_ticks = cfg_data;
          REG_DASH_UNITS:    dash_units = cfg_data[FACT_W-1:0];
          REG_WORD_UNITS:    word_units = cfg_data[FACT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_segments(s_tdata);
      end
    end
    pending = expected_segments.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: drives characters and register writes into morse_character_keyer_core with random
// idling on both sides and gives the verdict. Depends on mck_pkg and mck_segment_checker.
module tb;
  import mck_pkg::*;

  localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int KEYED_PER_PHASE = 47;
  localparam int PHASES          = 8;
  localparam int SETTLE_CYCLES   = 32;
  localparam int STALL_LIMIT     = 2000;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [CHAR_W-1:0]  s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index;
  logic [BASE_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int segments_checked;
  int chars_sent;
  int keyed_sent;
  int dropped_sent;
  int settings_used;
  int idle_cycles;
  bit steady;

  morse_character_keyer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mck_segment_checker segment_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .segments_checked (segments_checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, giving up", $time, STALL_LIMIT);
      $display("** morse_character_keyer_core: FAILED **");
      $finish;
    end
  end

  function automatic bit is_keyed(input logic [CHAR_W-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == " ";
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = "A" + CHAR_W'($urandom_range(0, 25));
      3, 4:    c = "a" + CHAR_W'($urandom_range(0, 25));
      5, 6:    c = "0" + CHAR_W'($urandom_range(0, 9));
      7:       c = " ";
      default: c = CHAR_W'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // random output stalls in bursts, none while steady
  task automatic drive_ready();
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!steady && hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        hold = $urandom_range(0, 7);
      end else begin
        m_tready <= 1'b1;
      end
    end
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= CHAR_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
    if (is_keyed(c)) keyed_sent++;
    else dropped_sent++;
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [BASE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every segment, then let a dropped character finish
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    string             opening;
    logic [CHAR_W-1:0] c;
    logic [BASE_W-1:0] base_val;
    logic [BASE_W-1:0] short_val;
    logic [BASE_W-1:0] long_val;
    int                n;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    steady    = 1'b0;
    opening   = "ETAZazQY09 5@[{/:Hj";
    fork
      drive_ready();
    join_none
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: field extremes, both cases, digits, space and dropped codes
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'hC1);
    send_char(8'h60);
    send_char(8'h7F);
    for (int i = 0; i < opening.len(); i++) send_char(opening[i]);
    settings_used = 1;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_BASE_DURATION, 16'd1);
          write_reg(REG_DASH_UNITS, 16'd1);
          write_reg(REG_WORD_UNITS, 16'd1);
        end
        1: begin
          write_reg(REG_BASE_DURATION, 16'hFFFF);
          write_reg(REG_DASH_UNITS, 16'h000F);
          write_reg(REG_WORD_UNITS, 16'h000F);
        end
        2: begin
          write_reg(REG_BASE_DURATION, 16'h0000);
          write_reg(REG_DASH_UNITS, 16'h0007);
          write_reg(REG_WORD_UNITS, 16'h000B);
        end
        3: begin
          // zero factors, the dash one reached through masking of the upper data bits
          write_reg(REG_BASE_DURATION, BASE_W'($urandom_range(1, 65535)));
          write_reg(REG_DASH_UNITS, 16'hFFF0);
          write_reg(REG_WORD_UNITS, 16'h0000);
          write_reg(REG_UNUSED, 16'hFFFF);
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       base_val = BASE_W'($urandom_range(1, 8));
            1:       base_val = BASE_W'($urandom_range(65000, 65535));
            default: base_val = BASE_W'($urandom_range(1, 65535));
          endcase
          short_val = {12'($urandom), 4'($urandom_range(1, 15))};
          long_val  = {12'($urandom), 4'($urandom_range(1, 15))};
          if ($urandom_range(0, 9) == 0) short_val[3:0] = '0;
          if ($urandom_range(0, 9) == 0) long_val[3:0] = '0;
          write_reg(REG_WORD_UNITS, long_val);
          if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, BASE_W'($urandom));
          write_reg(REG_BASE_DURATION, base_val);
          write_reg(REG_DASH_UNITS, short_val);
        end
      endcase
      settings_used++;
      steady = (ph == PHASES - 1);
      n = 0;
      while (n < KEYED_PER_PHASE) begin
        c = pick_char();
        if (is_keyed(c)) n++;
        send_char(c);
        if (ph != PHASES - 1 && chars_sent % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      end
    end
    settle();

    $display("Sent %0d characters (%0d keyed, %0d dropped); %0d segments checked.",
             chars_sent, keyed_sent, dropped_sent, segments_checked);
    $display("Used %0d register settings, among them minimum, maximum, zero and masked values.",
             settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("** morse_character_keyer_core: PASSED **");
    end else begin
      $display("** morse_character_keyer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mck_pkg.sv
src/mck_dur_mul.sv
src/morse_character_keyer_core.sv
src/mck_checker.sv
dv/mck_segment_checker.sv
dv/tb.sv
